### rtl/mat3_pkg.sv
// shared types, constants and the sequencer program for the 3x3 matrix core
package mat3_pkg;

	localparam int ELEMENT_W = 16;
	localparam int VALUE_W   = 33;
	localparam int MODE_W    = 2;

	localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

	typedef logic [2:0] step_t;
	typedef logic [2:0] cond_t;

	// jump conditions
	localparam cond_t C_NONE       = 3'd0;
	localparam cond_t C_ALWAYS     = 3'd1;
	localparam cond_t C_MORE_LOADS = 3'd2;
	localparam cond_t C_MORE_K     = 3'd3;
	localparam cond_t C_MORE_CELLS = 3'd4;

	// program steps
	localparam step_t S_LOAD = 3'd0;
	localparam step_t S_READ = 3'd1;
	localparam step_t S_MUL  = 3'd2;
	localparam step_t S_ACC  = 3'd3;
	localparam step_t S_EMIT = 3'd4;
	localparam step_t S_DONE = 3'd5;

	typedef struct packed {
		logic  in_en;   // take a word, hold step until one arrives
		logic  rd_en;   // read both matrix memories
		logic  mul_en;  // register product and element-wise result
		logic  acc_en;  // update accumulator
		logic  emit;    // load output register, hold until slot free
		cond_t cond;
		step_t target;
	} ctl_t;

	function automatic ctl_t prog_word(input step_t pc);
		ctl_t w;
		w = '{in_en: 1'b0, rd_en: 1'b0, mul_en: 1'b0, acc_en: 1'b0, emit: 1'b0,
			cond: C_ALWAYS, target: S_LOAD};
		unique case (pc)
			S_LOAD: begin
				w.in_en  = 1'b1;
				w.cond   = C_MORE_LOADS;
				w.target = S_LOAD;
			end
			S_READ: begin
				w.rd_en = 1'b1;
				w.cond  = C_NONE;
			end
			S_MUL: begin
				w.mul_en = 1'b1;
				w.cond   = C_NONE;
			end
			S_ACC: begin
				w.acc_en = 1'b1;
				w.cond   = C_MORE_K;
				w.target = S_READ;
			end
			S_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = C_MORE_CELLS;
				w.target = S_READ;
			end
			S_DONE: begin
				w.cond   = C_ALWAYS;
				w.target = S_LOAD;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = S_LOAD;
			end
		endcase
		return w;
	endfunction

endpackage

### rtl/mat3_if.sv
// valid/ready channels for input elements and result values

interface mat3_elem_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [mat3_pkg::ELEMENT_W-1:0]    element;

	modport source (output valid, output element, input ready);
	modport sink   (input valid, input element, output ready);
endinterface

interface mat3_res_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [mat3_pkg::VALUE_W-1:0]      value;
	logic                                     last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

### rtl/matrix3x3_add_sub_mul_core.sv
// microcoded DIMxDIM matrix add / subtract / multiply core
//
// elements: 2*DIM*DIM signed words, matrix A then matrix B, row-major, one
//   word per cycle while the sequencer sits at its load step.
// results: DIM*DIM words, row-major, last marks the final one.
// cfg_we / cfg_wdata write the mode register (add, subtract, multiply); it is
//   to be written only while the core is idle; the core does not enforce this.
// after the final element the sequencer runs read, multiply and accumulate for
//   each term (DIM terms in multiply mode, one in the element-wise modes), then
//   emits the result; a done step follows the last result before loads resume.
//   The single read port of each matrix memory and the registered multiplier
//   set this step sequence.
// the output register holds a result until it is taken; the emit step waits
//   on it, so a stalled receiver stalls the program but no word is lost.
// loading of the next pair starts while the last result still waits.
// reset clears the sequencer, counters, mode and output valid; the matrix
//   memories are not cleared, every entry is written before it is read.
module matrix3x3_add_sub_mul_core #(
	parameter int DIM        = 3,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mat3_pkg::MODE_W-1:0]     cfg_wdata,
	mat3_elem_if.sink                       elements,
	mat3_res_if.source                      results
);

	localparam int CELLS = DIM * DIM;
	localparam int TOTAL = 2 * CELLS;
	localparam int AW    = $clog2(CELLS);
	localparam int IW    = $clog2(DIM);
	localparam int LW    = $clog2(TOTAL);
	localparam int PW    = 2 * ELEM_WIDTH;
	localparam int VW    = mat3_pkg::VALUE_W;

	localparam logic [IW-1:0] DIM_LAST   = IW'(DIM - 1);
	localparam logic [LW-1:0] LOAD_LAST  = LW'(TOTAL - 1);
	localparam logic [LW-1:0] CELLS_L    = LW'(CELLS);

	logic [mat3_pkg::MODE_W-1:0] mode_q;
	mat3_pkg::step_t             pc_q;
	mat3_pkg::ctl_t              ctl;
	logic [LW-1:0]               load_cnt_q;
	logic [IW-1:0]               row_q, col_q, k_q;

	logic signed [ELEM_WIDTH-1:0] mem_a [CELLS];
	logic signed [ELEM_WIDTH-1:0] mem_b [CELLS];
	logic signed [ELEM_WIDTH-1:0] a_rd_q, b_rd_q;

	logic signed [VW-1:0] prod_q, ew_q, acc_q;
	logic signed [VW-1:0] value_q;
	logic                 last_q, out_valid_q;

	logic                  in_acc, out_slot, advance, take, mul_mode, last_cell;
	logic [AW-1:0]         a_addr, b_addr, wr_addr;
	logic signed [ELEM_WIDTH-1:0] elem_in;
	logic signed [PW-1:0]  prod;
	logic signed [ELEM_WIDTH:0] ew;
	logic signed [63:0]    prod_ext, ew_ext;

	assign ctl       = mat3_pkg::prog_word(pc_q);
	assign mul_mode  = mode_q[1];   // code three also selects the product
	assign last_cell = (row_q == DIM_LAST) && (col_q == DIM_LAST);

	assign elements.ready = ctl.in_en;
	assign in_acc         = elements.valid && ctl.in_en;
	assign out_slot       = !out_valid_q || results.ready;
	assign advance        = !(ctl.in_en && !elements.valid) && !(ctl.emit && !out_slot);

	assign results.valid = out_valid_q;
	assign results.value = value_q;
	assign results.last  = last_q;

	always_comb begin
		unique case (ctl.cond)
			mat3_pkg::C_NONE:       take = 1'b0;
			mat3_pkg::C_ALWAYS:     take = 1'b1;
			mat3_pkg::C_MORE_LOADS: take = (load_cnt_q != LOAD_LAST);
			mat3_pkg::C_MORE_K:     take = mul_mode && (k_q != DIM_LAST);
			mat3_pkg::C_MORE_CELLS: take = !last_cell;
			default:                take = 1'b0;
		endcase
	end

	// operand addresses
	always_comb begin
		if (mul_mode) begin
			a_addr = AW'(row_q * DIM + k_q);
			b_addr = AW'(k_q * DIM + col_q);
		end else begin
			a_addr = AW'(row_q * DIM + col_q);
			b_addr = AW'(row_q * DIM + col_q);
		end
	end

	assign elem_in = ELEM_WIDTH'($unsigned(elements.element));
	assign wr_addr = (load_cnt_q < CELLS_L) ? load_cnt_q[AW-1:0]
		: AW'(load_cnt_q - CELLS_L);

	always_ff @(posedge clk) begin
		if (in_acc && load_cnt_q < CELLS_L)
			mem_a[wr_addr] <= elem_in;
		if (ctl.rd_en)
			a_rd_q <= mem_a[a_addr];
	end

	always_ff @(posedge clk) begin
		if (in_acc && load_cnt_q >= CELLS_L)
			mem_b[wr_addr] <= elem_in;
		if (ctl.rd_en)
			b_rd_q <= mem_b[b_addr];
	end

	assign prod     = a_rd_q * b_rd_q;
	assign prod_ext = 64'(prod);
	assign ew       = (mode_q == mat3_pkg::MODE_SUB)
		? ((ELEM_WIDTH+1)'(a_rd_q) - (ELEM_WIDTH+1)'(b_rd_q))
		: ((ELEM_WIDTH+1)'(a_rd_q) + (ELEM_WIDTH+1)'(b_rd_q));
	assign ew_ext   = 64'(ew);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= prod_ext[VW-1:0];
			ew_q   <= ew_ext[VW-1:0];
		end
		if (ctl.acc_en) begin
			if (mul_mode)
				acc_q <= ((k_q == '0) ? '0 : acc_q) + prod_q;
			else
				acc_q <= ew_q;
		end
		if (ctl.emit && out_slot) begin
			value_q <= acc_q;
			last_q  <= last_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= mat3_pkg::MODE_ADD;
			pc_q        <= mat3_pkg::S_LOAD;
			load_cnt_q  <= '0;
			row_q       <= '0;
			col_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				mode_q <= cfg_wdata;
			if (advance)
				pc_q <= take ? ctl.target : mat3_pkg::step_t'(pc_q + 1'b1);
			if (in_acc)
				load_cnt_q <= (load_cnt_q == LOAD_LAST) ? '0 : load_cnt_q + 1'b1;
			if (ctl.acc_en && take)
				k_q <= k_q + 1'b1;
			if (ctl.emit && out_slot) begin
				out_valid_q <= 1'b1;
				k_q         <= '0;
				if (col_q == DIM_LAST) begin
					col_q <= '0;
					row_q <= (row_q == DIM_LAST) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// final element hands control to the compute program
	a_final_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && load_cnt_q == LOAD_LAST) |=> pc_q == mat3_pkg::S_READ)
		else $error("final load did not start compute");

	// the term index only moves in multiply mode
	a_k_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != '0) |-> mul_mode)
		else $error("term index moved outside multiply mode");

	// last result leaves the cell counters at the origin
	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && out_slot && last_cell) |=> (row_q == '0 && col_q == '0 && k_q == '0))
		else $error("cell counters not cleared after last result");

	// no partial pair is held while computing
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != mat3_pkg::S_LOAD) |-> load_cnt_q == '0)
		else $error("load count nonzero during compute");

endmodule
